FILE: hdl/fssc_pkg.sv
// Shared constants and helpers for the fire step size controller.
package fssc_pkg;

   localparam int unsigned DataWidth  = 32;
   localparam int unsigned FracWidth  = 16;
   localparam int unsigned AlphaWidth = 17;
   localparam int unsigned GrowWidth  = 19;
   localparam int unsigned CountWidth = 16;
   localparam int unsigned CsrIdxWidth = 3;

   localparam logic [DataWidth-1:0]  DtStartRst     = 32'd65536;
   localparam logic [DataWidth-1:0]  DtMaxRst       = 32'd655360;
   localparam logic [DataWidth-1:0]  DtMinRst       = 32'd655;
   localparam logic [GrowWidth-1:0]  GrowFactorRst  = 19'd72089;
   localparam logic [AlphaWidth-1:0] ShrinkRst      = 17'd32768;
   localparam logic [AlphaWidth-1:0] AlphaStartRst  = 17'd16384;
   localparam logic [AlphaWidth-1:0] AlphaDecayRst  = 17'd64880;
   localparam logic [CountWidth-1:0] PositiveMinRst = 16'd20;

   localparam logic [CountWidth:0]   NegativeMax  = 17'd2000;
   localparam logic                  InitialDelay = 1'b1;
   // 1.5 * move limit, scaled to the Q32 product of speed and step
   localparam logic [63:0]           MoveLimitQ   = 64'd9663676416;
   localparam logic [AlphaWidth-1:0] OneQ         = 17'd65536;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_DT_START      = 3'd0,
      CSR_DT_MAX        = 3'd1,
      CSR_DT_MIN        = 3'd2,
      CSR_GROW_FACTOR   = 3'd3,
      CSR_SHRINK_FACTOR = 3'd4,
      CSR_ALPHA_START   = 3'd5,
      CSR_ALPHA_DECAY   = 3'd6,
      CSR_POSITIVE_MIN  = 3'd7
   } csr_idx_type;

   function automatic logic [AlphaWidth-1:0] clamp_alpha(input logic [AlphaWidth:0] a);
      clamp_alpha = (a > {1'b0, OneQ}) ? OneQ : a[AlphaWidth-1:0];
   endfunction

endpackage

FILE: hdl/fssc_div.sv
// Bit-serial restoring divider: (dividend << 32) / divisor, one quotient bit a cycle.
module fssc_div
   import fssc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [DataWidth-1:0]   dividend,
   input  logic [DataWidth-1:0]   divisor,
   output logic [2*DataWidth-1:0] quotient,
   output logic                   done
);

   logic [2*DataWidth-1:0] shreg_ff, shreg_in;
   logic [DataWidth-1:0]   rem_ff, rem_in;
   logic [5:0]             cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DataWidth:0]     rem_w;
   logic                   ge;

   always_comb begin
      rem_w    = {rem_ff, shreg_ff[2*DataWidth-1]};
      ge       = rem_w >= {1'b0, divisor};
      shreg_in = shreg_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shreg_in = {dividend, {DataWidth{1'b0}}};
         rem_in   = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // shift one dividend bit into the remainder, one quotient bit out
         rem_in   = ge ? DataWidth'(rem_w - {1'b0, divisor}) : rem_w[DataWidth-1:0];
         shreg_in = {shreg_ff[2*DataWidth-2:0], ge};
         cnt_in   = cnt_ff + 6'd1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shreg_ff <= shreg_in;
      rem_ff   <= rem_in;
   end

   assign quotient = shreg_ff;
   assign done     = done_ff;

endmodule

FILE: hdl/fssc_sqrt.sv
// Digit-serial integer square root, two radicand bits a cycle.
module fssc_sqrt
   import fssc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [2*DataWidth-1:0] radicand,
   output logic [DataWidth-1:0]   root,
   output logic                   done
);

   logic [2*DataWidth-1:0] shreg_ff, shreg_in;
   logic [DataWidth+1:0]   rem_ff, rem_in;
   logic [DataWidth-1:0]   root_ff, root_in;
   logic [4:0]             cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DataWidth+3:0]   rem_w;
   logic [DataWidth+3:0]   trial;
   logic                   ge;

   always_comb begin
      rem_w    = {rem_ff, shreg_ff[2*DataWidth-1 -: 2]};
      trial    = {2'b00, root_ff, 2'b01};
      ge       = rem_w >= trial;
      shreg_in = shreg_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shreg_in = radicand;
         rem_in   = '0;
         root_in  = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = ge ? (DataWidth+2)'(rem_w - trial) : rem_w[DataWidth+1:0];
         root_in  = {root_ff[DataWidth-2:0], ge};
         shreg_in = {shreg_ff[2*DataWidth-3:0], 2'b00};
         cnt_in   = cnt_ff + 5'd1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shreg_ff <= shreg_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

FILE: hdl/fire_step_size_controller.sv
// Top level of the fire step size controller: sequencer, shared multiplier, state.
//
//  channel  dir  handshake              payload
//  req      in   req_valid/req_ready    restart, power, force_sq, velocity_sq, peak_speed
//  rsp      out  rsp_valid/rsp_ready    step_size, velocity_keep, force_mix, step_back, failed
//  csr      in   csr_we                 csr_index, csr_wdata
//
// One item at a time. A failure goes straight to the result; the initial delay only checks
// displacement; other non-positive power shrinks the step first. With nonzero force, positive
// power computes the mix through the serial divider and serial root; a growth step adds the
// grow and decay states. Each displacement shrink loop pass uses the shared multiplier.
// Reset is synchronous and restores all but the operand and product registers at once.
// A result holds on the rsp port until transferred; req_ready rises in the cycle after that.
module fire_step_size_controller
   import fssc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_restart,
   input  logic signed [31:0]     req_power,
   input  logic [DataWidth-1:0]   req_force_sq,
   input  logic [DataWidth-1:0]   req_velocity_sq,
   input  logic [DataWidth-1:0]   req_peak_speed,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [DataWidth-1:0]   rsp_step_size,
   output logic [AlphaWidth-1:0]  rsp_velocity_keep,
   output logic [DataWidth-1:0]   rsp_force_mix,
   output logic                   rsp_step_back,
   output logic                   rsp_failed,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [DataWidth-1:0]   csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_GROW, S_GROW_W, S_DECAY, S_DECAY_W, S_RATIO, S_DIV, S_SQRT,
      S_MIX, S_MIX_W, S_NSHR, S_NSHR_W, S_LCHK, S_LCHK_W, S_LSHR, S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [DataWidth-1:0]  dt_start_ff, dt_max_ff, dt_min_ff;
   logic [GrowWidth-1:0]  grow_ff;
   logic [AlphaWidth-1:0] shrink_ff, alpha_start_ff, alpha_decay_ff;
   logic [CountWidth-1:0] pos_min_ff;

   logic [DataWidth-1:0]  step_ff, step_in;
   logic [AlphaWidth-1:0] alpha_ff, alpha_in;
   logic [CountWidth-1:0] pos_ff, pos_in, neg_ff, neg_in;
   logic [DataWidth-1:0]  iter_ff, iter_in;
   logic [AlphaWidth-1:0] keep_ff, keep_in;
   logic [DataWidth-1:0]  mix_ff, mix_in;
   logic                  back_ff, back_in, fail_ff, fail_in;
   logic [DataWidth-1:0]  fsq_ff, fsq_in, vsq_ff, vsq_in, peak_ff, peak_in;
   logic                  div_start_ff, div_start_in, sqrt_start_ff, sqrt_start_in;
   logic [2*DataWidth-1:0] prod_ff;

   logic [DataWidth-1:0]  mul_a, mul_b;
   logic [2*DataWidth-1:0] quotient;
   logic [DataWidth-1:0]  root;
   logic                  div_done, sqrt_done;

   logic [DataWidth-1:0]  b_step, b_iter;
   logic [AlphaWidth-1:0] b_alpha;
   logic [CountWidth-1:0] b_pos, b_neg;
   logic [CountWidth:0]   np, nn;
   logic                  positive;
   logic [DataWidth+2:0]  grown;
   logic [DataWidth:0]    scaled;
   logic [DataWidth-1:0]  shr;

   fssc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (vsq_ff),
      .divisor  (fsq_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   fssc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start_ff),
      .radicand (quotient),
      .root     (root),
      .done     (sqrt_done)
   );

   // operand select for the one shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_GROW: begin
            mul_a = step_ff;
            mul_b = DataWidth'(grow_ff);
         end
         S_DECAY: begin
            mul_a = DataWidth'(alpha_ff);
            mul_b = DataWidth'(alpha_decay_ff);
         end
         S_MIX: begin
            mul_a = DataWidth'(alpha_ff);
            mul_b = root;
         end
         S_NSHR, S_LSHR: begin
            mul_a = step_ff;
            mul_b = DataWidth'(shrink_ff);
         end
         S_LCHK: begin
            mul_a = peak_ff;
            mul_b = step_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      alpha_in      = alpha_ff;
      pos_in        = pos_ff;
      neg_in        = neg_ff;
      iter_in       = iter_ff;
      keep_in       = keep_ff;
      mix_in        = mix_ff;
      back_in       = back_ff;
      fail_in       = fail_ff;
      fsq_in        = fsq_ff;
      vsq_in        = vsq_ff;
      peak_in       = peak_ff;
      div_start_in  = 1'b0;
      sqrt_start_in = 1'b0;

      b_step   = req_restart ? dt_start_ff : step_ff;
      b_alpha  = req_restart ? clamp_alpha({1'b0, alpha_start_ff}) : alpha_ff;
      b_pos    = req_restart ? '0 : pos_ff;
      b_neg    = req_restart ? '0 : neg_ff;
      b_iter   = req_restart ? '0 : iter_ff;
      np       = {1'b0, b_pos} + 17'd1;
      nn       = {1'b0, b_neg} + 17'd1;
      positive = !req_power[31] && (req_power != '0);
      grown    = prod_ff[2*DataWidth-14:FracWidth];
      scaled   = prod_ff[DataWidth+FracWidth:FracWidth];
      shr      = prod_ff[DataWidth+FracWidth-1:FracWidth];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               step_in  = b_step;
               alpha_in = b_alpha;
               iter_in  = (b_iter == '1) ? b_iter : b_iter + 32'd1;
               fsq_in   = req_force_sq;
               vsq_in   = req_velocity_sq;
               peak_in  = req_peak_speed;
               fail_in  = 1'b0;
               back_in  = 1'b0;
               if (req_restart) begin
                  keep_in = '0;
                  mix_in  = '0;
               end
               if (positive) begin
                  neg_in   = '0;
                  pos_in   = np[CountWidth] ? '1 : np[CountWidth-1:0];
                  state_in = (np > {1'b0, pos_min_ff}) ? S_GROW : S_RATIO;
               end else begin
                  pos_in = '0;
                  neg_in = nn[CountWidth] ? '1 : nn[CountWidth-1:0];
                  if (nn > NegativeMax) begin
                     fail_in  = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     back_in = 1'b1;
                     peak_in = '0;
                     if (InitialDelay && (iter_in < {16'd0, pos_min_ff})) begin
                        state_in = S_LCHK;
                     end else begin
                        state_in = S_NSHR;
                     end
                  end
               end
            end
         end
         S_GROW:   state_in = S_GROW_W;
         S_GROW_W: begin
            step_in  = (grown > {3'b000, dt_max_ff}) ? dt_max_ff : grown[DataWidth-1:0];
            state_in = S_DECAY;
         end
         S_DECAY:  state_in = S_DECAY_W;
         S_DECAY_W: begin
            alpha_in = clamp_alpha(prod_ff[AlphaWidth+FracWidth:FracWidth]);
            state_in = S_RATIO;
         end
         S_RATIO: begin
            keep_in = OneQ - alpha_ff;
            if (fsq_ff == '0) begin
               mix_in   = '0;
               state_in = S_LCHK;
            end else begin
               div_start_in = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               sqrt_start_in = 1'b1;
               state_in      = S_SQRT;
            end
         end
         S_SQRT: begin
            if (sqrt_done) begin
               state_in = S_MIX;
            end
         end
         S_MIX:    state_in = S_MIX_W;
         S_MIX_W: begin
            mix_in   = scaled[DataWidth] ? '1 : scaled[DataWidth-1:0];
            state_in = S_LCHK;
         end
         S_NSHR:   state_in = S_NSHR_W;
         S_NSHR_W: begin
            if (shr >= dt_min_ff) begin
               step_in = shr;
            end
            alpha_in = clamp_alpha({1'b0, alpha_start_ff});
            state_in = S_LCHK;
         end
         S_LCHK:   state_in = S_LCHK_W;
         S_LCHK_W: state_in = (prod_ff > MoveLimitQ) ? S_LSHR : S_DONE;
         S_LSHR: begin
            // product of the shrink is ready in the next cycle; reuse S_NSHR_W-style check
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // the loop shrink result lands in the cycle after S_LSHR; judge it here
   logic lshr_w_ff;
   logic lshr_w_in;
   logic lshr_take;

   assign lshr_w_in = (state_ff == S_LSHR);
   assign lshr_take = lshr_w_ff && (shr >= dt_min_ff) && (shr < step_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         dt_start_ff    <= DtStartRst;
         dt_max_ff      <= DtMaxRst;
         dt_min_ff      <= DtMinRst;
         grow_ff        <= GrowFactorRst;
         shrink_ff      <= ShrinkRst;
         alpha_start_ff <= AlphaStartRst;
         alpha_decay_ff <= AlphaDecayRst;
         pos_min_ff     <= PositiveMinRst;
         step_ff        <= DtStartRst;
         alpha_ff       <= clamp_alpha({1'b0, AlphaStartRst});
         pos_ff         <= '0;
         neg_ff         <= '0;
         iter_ff        <= '0;
         keep_ff        <= '0;
         mix_ff         <= '0;
         back_ff        <= 1'b0;
         fail_ff        <= 1'b0;
         div_start_ff   <= 1'b0;
         sqrt_start_ff  <= 1'b0;
         lshr_w_ff      <= 1'b0;
      end else begin
         if (lshr_w_ff) begin
            // hold S_DONE only when the shrink stops the loop
            state_ff <= lshr_take ? S_LCHK : S_DONE;
         end else begin
            state_ff <= state_in;
         end
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_DT_START:      dt_start_ff    <= csr_wdata;
               CSR_DT_MAX:        dt_max_ff      <= csr_wdata;
               CSR_DT_MIN:        dt_min_ff      <= csr_wdata;
               CSR_GROW_FACTOR:   grow_ff        <= csr_wdata[GrowWidth-1:0];
               CSR_SHRINK_FACTOR: shrink_ff      <= csr_wdata[AlphaWidth-1:0];
               CSR_ALPHA_START:   alpha_start_ff <= csr_wdata[AlphaWidth-1:0];
               CSR_ALPHA_DECAY:   alpha_decay_ff <= csr_wdata[AlphaWidth-1:0];
               CSR_POSITIVE_MIN:  pos_min_ff     <= csr_wdata[CountWidth-1:0];
               default:           pos_min_ff     <= pos_min_ff;
            endcase
         end
         step_ff       <= lshr_take ? shr : step_in;
         alpha_ff      <= alpha_in;
         pos_ff        <= pos_in;
         neg_ff        <= neg_in;
         iter_ff       <= iter_in;
         keep_ff       <= keep_in;
         mix_ff        <= mix_in;
         back_ff       <= back_in;
         fail_ff       <= fail_in;
         div_start_ff  <= div_start_in;
         sqrt_start_ff <= sqrt_start_in;
         lshr_w_ff     <= lshr_w_in;
      end
      fsq_ff  <= fsq_in;
      vsq_ff  <= vsq_in;
      peak_ff <= peak_in;
      prod_ff <= mul_a * mul_b;
   end

   assign req_ready         = (state_ff == S_IDLE) && !lshr_w_ff;
   assign rsp_valid         = (state_ff == S_DONE) && !lshr_w_ff;
   assign rsp_step_size     = step_ff;
   assign rsp_velocity_keep = keep_ff;
   assign rsp_force_mix     = mix_ff;
   assign rsp_step_back     = back_ff;
   assign rsp_failed        = fail_ff;

endmodule

FILE: verif/fire_step_size_controller_test.sv
// Self-checking testbench for the fire step size controller: random and directed iterations.
module fire_step_size_controller_test;
   import fssc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned StallLimit = 6000;
   localparam longint unsigned DispLimit = 64'd98304 * 64'd3 * 64'd32768;
   localparam int unsigned NegRunMax = 2000;

   typedef struct {
      logic        restart;
      logic [31:0] power;
      logic [31:0] force_sq;
      logic [31:0] velocity_sq;
      logic [31:0] peak_speed;
   } iteration_type;

   typedef struct {
      logic [31:0] step_size;
      logic [16:0] velocity_keep;
      logic [31:0] force_mix;
      logic        step_back;
      logic        failed;
   } step_plan_type;

   class step_plan_tracker_type;
      logic [31:0] dt_start, dt_max, dt_min;
      logic [18:0] grow_factor;
      logic [16:0] shrink_factor, alpha_start, alpha_decay;
      logic [15:0] positive_min;
      logic [31:0] step_now, iteration, mix_last;
      logic [16:0] alpha_now, keep_last;
      logic [15:0] positive_run, negative_run;
      step_plan_type pending_plans[$];
      int unsigned mismatches, plans_checked, fail_flags, backs;

      function new();
         dt_start = DtStartRst;
         dt_max = DtMaxRst;
         dt_min = DtMinRst;
         grow_factor = GrowFactorRst;
         shrink_factor = ShrinkRst;
         alpha_start = AlphaStartRst;
         alpha_decay = AlphaDecayRst;
         positive_min = PositiveMinRst;
         mismatches = 0;
         plans_checked = 0;
         fail_flags = 0;
         backs = 0;
         restart_run();
      endfunction

      function logic [16:0] sat_alpha(longint unsigned a);
         return (a > 65536) ? 17'd65536 : a[16:0];
      endfunction

      function void restart_run();
         step_now = dt_start;
         alpha_now = sat_alpha(alpha_start);
         positive_run = 0;
         negative_run = 0;
         iteration = 0;
         keep_last = 0;
         mix_last = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [31:0] v);
         case (idx)
            CSR_DT_START:      dt_start = v;
            CSR_DT_MAX:        dt_max = v;
            CSR_DT_MIN:        dt_min = v;
            CSR_GROW_FACTOR:   grow_factor = v[18:0];
            CSR_SHRINK_FACTOR: shrink_factor = v[16:0];
            CSR_ALPHA_START:   alpha_start = v[16:0];
            CSR_ALPHA_DECAY:   alpha_decay = v[16:0];
            CSR_POSITIVE_MIN:  positive_min = v[15:0];
            default: ;
         endcase
      endfunction

      function longint unsigned int_root(longint unsigned x);
         longint unsigned r, b;
         r = 0;
         b = 64'h4000_0000_0000_0000;
         while (b > x) b >>= 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function logic [31:0] shrink_of(logic [31:0] dt);
         longint unsigned p;
         p = (64'(dt) * 64'(shrink_factor)) >> 16;
         return p[31:0];
      endfunction

      // advance the controller state by one accepted iteration
      function void note_iteration(iteration_type it);
         step_plan_type   plan;
         logic            pos;
         logic [31:0]     peak, s;
         longint unsigned g, q, m;
         int unsigned     np, nn;
         plan.step_back = 0;
         plan.failed = 0;
         peak = it.peak_speed;
         pos = !it.power[31] && (it.power != 0);
         if (it.restart) restart_run();
         if (iteration != 32'hFFFF_FFFF) iteration++;
         if (pos) begin
            np = positive_run + 1;
            negative_run = 0;
            positive_run = (np > 16'hFFFF) ? 16'hFFFF : np[15:0];
            if (np > positive_min) begin
               g = (64'(step_now) * 64'(grow_factor)) >> 16;
               step_now = (g > dt_max) ? dt_max : g[31:0];
               alpha_now = sat_alpha((64'(alpha_now) * 64'(alpha_decay)) >> 16);
            end
            keep_last = 17'd65536 - alpha_now;
            if (it.force_sq == 0) begin
               mix_last = 0;
            end else begin
               q = {it.velocity_sq, 32'h0} / 64'(it.force_sq);
               m = (64'(alpha_now) * int_root(q)) >> 16;
               mix_last = (m > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
            end
         end else begin
            nn = negative_run + 1;
            positive_run = 0;
            negative_run = (nn > 16'hFFFF) ? 16'hFFFF : nn[15:0];
            if (nn > NegRunMax) begin
               plan.failed = 1;
            end else begin
               // hold step and alpha during the initial delay
               if (!(InitialDelay && iteration < positive_min)) begin
                  s = shrink_of(step_now);
                  if (s >= dt_min) step_now = s;
                  alpha_now = sat_alpha(alpha_start);
               end
               plan.step_back = 1;
               peak = 0;
            end
         end
         if (!plan.failed) begin
            while (64'(peak) * 64'(step_now) > DispLimit) begin
               s = shrink_of(step_now);
               if (s < dt_min || s >= step_now) break;
               step_now = s;
            end
         end
         plan.step_size = step_now;
         plan.velocity_keep = keep_last;
         plan.force_mix = mix_last;
         pending_plans.push_back(plan);
      endfunction

      function void check_plan(step_plan_type got);
         step_plan_type want;
         if (pending_plans.size() == 0) begin
            $error("result with no iteration pending");
            mismatches++;
            return;
         end
         want = pending_plans.pop_front();
         plans_checked++;
         if (got.failed) fail_flags++;
         if (got.step_back) backs++;
         if (got.step_size !== want.step_size) begin
            $error("step_size: expected %0d, got %0d", want.step_size, got.step_size);
            mismatches++;
         end
         if (got.velocity_keep !== want.velocity_keep) begin
            $error("velocity_keep: expected %0d, got %0d", want.velocity_keep,
                   got.velocity_keep);
            mismatches++;
         end
         if (got.force_mix !== want.force_mix) begin
            $error("force_mix: expected %0d, got %0d", want.force_mix, got.force_mix);
            mismatches++;
         end
         if (got.step_back !== want.step_back) begin
            $error("step_back: expected %0d, got %0d", want.step_back, got.step_back);
            mismatches++;
         end
         if (got.failed !== want.failed) begin
            $error("failed: expected %0d, got %0d", want.failed, got.failed);
            mismatches++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_restart = 1'b0;
   logic signed [31:0]     req_power = '0;
   logic [31:0]            req_force_sq = '0;
   logic [31:0]            req_velocity_sq = '0;
   logic [31:0]            req_peak_speed = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [31:0]            rsp_step_size;
   logic [16:0]            rsp_velocity_keep;
   logic [31:0]            rsp_force_mix;
   logic                   rsp_step_back;
   logic                   rsp_failed;
   logic                   csr_we = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [31:0]            csr_wdata = '0;

   step_plan_tracker_type tracker = new();
   bit               steady = 0;
   int unsigned      idle_cycles = 0;
   int unsigned      sent = 0;

   fire_step_size_controller dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog on transfers of either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("FAIL fire_step_size_controller");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      step_plan_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.step_size = rsp_step_size;
         got.velocity_keep = rsp_velocity_keep;
         got.force_mix = rsp_force_mix;
         got.step_back = rsp_step_back;
         got.failed = rsp_failed;
         tracker.check_plan(got);
      end
   end

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // result side back-pressure
   initial begin
      int unsigned hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_ready = 1'b0;
            hold--;
         end else begin
            rsp_ready = 1'b1;
            hold = gap_len();
         end
      end
   end

   task automatic write_reg(csr_idx_type idx, logic [31:0] v);
      csr_index = idx;
      csr_wdata = v;
      csr_we = 1'b1;
      @(negedge clock);
      csr_we = 1'b0;
      tracker.write_reg(idx, v);
   endtask

   task automatic send_iteration(iteration_type it);
      int unsigned g;
      req_restart = it.restart;
      req_power = it.power;
      req_force_sq = it.force_sq;
      req_velocity_sq = it.velocity_sq;
      req_peak_speed = it.peak_speed;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      tracker.note_iteration(it);
      sent++;
      @(negedge clock);
      g = gap_len();
      if (g > 0) begin
         req_valid = 1'b0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (tracker.pending_plans.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic iteration_type random_iteration(bit only_negative);
      iteration_type it;
      int unsigned   r;
      it.restart = ($urandom_range(0, 24) == 0);
      r = $urandom_range(0, 99);
      if (only_negative) r = 60 + $urandom_range(0, 39);
      if (r < 55) it.power = $urandom_range(1, 32'h7FFF_FFFF);
      else if (r < 70) it.power = 0;
      else it.power = $urandom | 32'h8000_0000;
      r = $urandom_range(0, 9);
      it.force_sq = (r == 0) ? 32'h0 : (r < 4) ? $urandom_range(1, 300) : $urandom;
      it.velocity_sq = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom;
      r = $urandom_range(0, 9);
      it.peak_speed = (r < 2) ? 32'h0 : (r < 7) ? $urandom_range(0, 400000) : $urandom;
      return it;
   endfunction

   task automatic load_config(int unsigned kind);
      logic [31:0] v[8];
      int unsigned r;
      v[0] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(256, 1 << 20);
      v[1] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1 << 16, 1 << 22);
      v[2] = $urandom_range(0, 1000);
      v[3] = $urandom_range(65536, 262144);
      r = $urandom_range(0, 9);
      v[4] = (r == 0) ? 0 : (r == 1) ? 65536 : $urandom_range(1, 49152);
      v[5] = $urandom_range(0, 65536);
      v[6] = $urandom_range(0, 65536);
      v[7] = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 30);
      case (kind)
         0: v = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 262144, 0, 65536, 65536, 0};
         1: v = '{0, 0, 32'hFFFF_FFFF, 65536, 65536, 0, 0, 65535};
         2: begin
            // cap below floor
            v[1] = 1000;
            v[2] = 50000;
            v[7] = 2;
         end
         default: ;
      endcase
      for (int i = 0; i < 8; i++) write_reg(csr_idx_type'(i), v[i]);
   endtask

   initial begin
      iteration_type it;
      iteration_type directed[$];
      repeat (7) @(negedge clock);
      reset = 1'b0;

      directed.push_back('{1, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h0});
      directed.push_back('{0, 32'h1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      directed.push_back('{0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0});
      directed.push_back('{0, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      directed.push_back('{0, 32'hFFFF_FFFF, 32'h1, 32'h1, 32'h1});
      directed.push_back('{0, 32'h0001_0000, 32'hFFFF_FFFF, 32'h1, 32'h0002_0000});
      directed.push_back('{1, 32'h0, 32'h0, 32'h0, 32'h0});
      for (int i = 0; i < 22; i++) directed.push_back('{0, 32'h100, 32'h10000, 32'h40000, 32'h0});
      directed.push_back('{0, 32'hFFFF_0000, 32'h10000, 32'h10000, 32'hFFFF_FFFF});
      directed.push_back('{0, 32'h100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      foreach (directed[i]) send_iteration(directed[i]);
      drain();

      for (int ph = 0; ph < 12; ph++) begin
         steady = (ph % 4 == 3);
         load_config(ph);
         for (int i = 0; i < 100; i++) begin
            it = random_iteration(0);
            if (i == 0) it.restart = 1;
            send_iteration(it);
         end
         drain();
      end

      // run of non-positive power back to back, then recover
      steady = 1;
      load_config(9);
      write_reg(CSR_POSITIVE_MIN, 5);
      it = random_iteration(0);
      it.restart = 1;
      it.power = 32'h10;
      send_iteration(it);
      for (int i = 0; i < 24; i++) begin
         it = random_iteration(1);
         it.restart = 0;
         send_iteration(it);
      end
      it.power = 32'h20;
      send_iteration(it);
      drain();

      $display("covered %0d iterations, %0d results checked, %0d step backs, %0d failures",
               sent, tracker.plans_checked, tracker.backs, tracker.fail_flags);
      if (tracker.mismatches == 0 && tracker.pending_plans.size() == 0) begin
         $display("PASS fire_step_size_controller");
      end else begin
         $display("FAIL fire_step_size_controller");
      end
      $finish;
   end

endmodule
